/* rtl/gsm7_pkg.sv */
package gsm7_pkg;

    localparam logic [6:0] ESC_SEPTET = 7'h1B;

    localparam logic [6:0] CHR_AT    = 7'h40;
    localparam logic [6:0] CHR_DOLLAR = 7'h24;
    localparam logic [6:0] CHR_UNDER = 7'h5F;

    localparam logic [6:0] SEP_AT     = 7'h00;
    localparam logic [6:0] SEP_DOLLAR = 7'h02;
    localparam logic [6:0] SEP_UNDER  = 7'h11;

    localparam int EXT_N = 8;
    localparam logic [6:0] EXT_CODE [EXT_N] = '{
        7'h3C, 7'h2F, 7'h3E, 7'h14, 7'h28, 7'h40, 7'h29, 7'h3D
    };
    localparam logic [6:0] EXT_CHAR [EXT_N] = '{
        7'h5B, 7'h5C, 7'h5D, 7'h5E, 7'h7B, 7'h7C, 7'h7D, 7'h7E
    };

    // one septet waiting to be mapped
    typedef struct packed {
        logic [6:0] septet;
        logic       ext;
        logic       last;
        logic       done;
    } t_rec;

    // up to two records written per accepted octet
    typedef struct packed {
        logic [1:0] cnt;
        t_rec       a;
        t_rec       b;
    } t_push;

    function automatic logic [6:0] map_default(input logic [6:0] s);
        logic [6:0] c;
        case (s)
            SEP_AT:     c = CHR_AT;
            SEP_DOLLAR: c = CHR_DOLLAR;
            SEP_UNDER:  c = CHR_UNDER;
            default:    c = s;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] map_extension(input logic [6:0] s);
        logic [6:0] c;
        c = s;
        for (int k = 0; k < EXT_N; k++) begin
            if (EXT_CODE[k] == s) begin
                c = EXT_CHAR[k];
            end
        end
        return c;
    endfunction

endpackage

/* rtl/gsm7_front.sv */
module gsm7_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_octet,
    input  logic                i_first_octet,
    input  logic [2:0]          i_fill_bits,
    input  logic [7:0]          i_septet_total,
    output gsm7_pkg::t_push     o_push
);
    import gsm7_pkg::*;

    logic [13:0] r_store, n_store;
    logic [3:0]  r_held,  n_held;
    logic [2:0]  r_skip,  n_skip;
    logic [7:0]  r_cnt,   n_cnt;
    logic [7:0]  r_total, n_total;
    logic        r_esc,   n_esc;

    always_comb begin
        logic [13:0] store;
        logic [3:0]  held;
        logic [2:0]  skip;
        logic [7:0]  cnt;
        logic [7:0]  total;
        logic        esc;
        logic [7:0]  sh;
        logic [6:0]  s;
        logic        em   [2];
        t_rec        rec  [2];

        store = r_store;
        held  = r_held;
        skip  = r_skip;
        cnt   = r_cnt;
        total = r_total;
        esc   = r_esc;
        sh    = '0;
        s     = '0;
        for (int k = 0; k < 2; k++) begin
            em[k]  = 1'b0;
            rec[k] = '0;
        end
        o_push = '0;

        if (i_fire) begin
            if (i_first_octet) begin
                store = '0;
                held  = '0;
                skip  = i_fill_bits;
                cnt   = '0;
                total = i_septet_total;
                esc   = 1'b0;
            end
            if (cnt < total) begin
                sh    = i_octet >> skip;
                // new bits land just above the ones already held
                store = store | (14'(sh) << held);
                held  = held + (4'd8 - {1'b0, skip});
                skip  = '0;
                // at most two septets fit in the store
                for (int k = 0; k < 2; k++) begin
                    if (held >= 4'd7 && cnt < total) begin
                        s     = store[6:0];
                        store = store >> 7;
                        held  = held - 4'd7;
                        cnt   = cnt + 8'd1;
                        rec[k].septet = s;
                        rec[k].done   = (cnt == total);
                        if (esc) begin
                            esc = 1'b0;
                            em[k] = (s != ESC_SEPTET);
                            rec[k].ext = 1'b1;
                        end else if (s == ESC_SEPTET) begin
                            esc = 1'b1;
                        end else begin
                            em[k] = 1'b1;
                        end
                    end
                end
                if (cnt >= total) begin
                    store = '0;
                    held  = '0;
                end
            end
            if (em[0] && em[1]) begin
                o_push.cnt = 2'd2;
                o_push.a   = rec[0];
                o_push.b   = rec[1];
                o_push.b.last = 1'b1;
            end else if (em[0] || em[1]) begin
                o_push.cnt = 2'd1;
                o_push.a   = em[0] ? rec[0] : rec[1];
                o_push.a.last = 1'b1;
            end
        end

        n_store = store;
        n_held  = held;
        n_skip  = skip;
        n_cnt   = cnt;
        n_total = total;
        n_esc   = esc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_held  <= '0;
            r_skip  <= '0;
            r_cnt   <= '0;
            r_total <= '0;
            r_esc   <= 1'b0;
        end else begin
            r_store <= n_store;
            r_held  <= n_held;
            r_skip  <= n_skip;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_esc   <= n_esc;
        end
    end

endmodule

/* rtl/gsm7_queue.sv */
module gsm7_queue #(
    parameter int DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gsm7_pkg::t_push             i_push,
    input  logic                        i_deq,
    output gsm7_pkg::t_rec              o_head,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);
    import gsm7_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] w_wptr1;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign w_wptr1 = inc(r_wptr);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count + CW'(i_push.cnt) - CW'(i_deq);
        if (i_push.cnt == 2'd1) begin
            n_wptr = w_wptr1;
        end else if (i_push.cnt == 2'd2) begin
            n_wptr = inc(w_wptr1);
        end
        if (i_deq) begin
            n_rptr = inc(r_rptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.a;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wptr1] <= i_push.b;
        end
    end

endmodule

/* rtl/gsm7_back.sv */
module gsm7_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gsm7_pkg::t_rec  i_head,
    input  logic            i_head_valid,
    input  logic            i_pop,
    output logic            o_deq,
    output logic            o_empty,
    output logic [6:0]      o_ascii_char,
    output logic            o_last_of_item,
    output logic            o_message_done
);
    import gsm7_pkg::*;

    logic       r_valid, n_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       r_done;
    logic       w_load;

    // output register refills whenever it is free or being taken
    assign w_load  = !r_valid || i_pop;
    assign o_deq   = w_load && i_head_valid;
    assign n_valid = i_head_valid || (r_valid && !i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_deq) begin
            r_char <= i_head.ext ? map_extension(i_head.septet) : map_default(i_head.septet);
            r_last <= i_head.last;
            r_done <= i_head.done;
        end
    end

    assign o_empty        = !r_valid;
    assign o_ascii_char   = r_char;
    assign o_last_of_item = r_last;
    assign o_message_done = r_done;

endmodule

/* rtl/gsm7_septet_unpack_to_ascii.sv */
// Unpacks GSM 7-bit user data into ASCII, one octet per cycle. The front end
// cuts up to two septets per octet, tracks fill bits, septet total and escape
// state, and writes the septets that produce characters into a DEPTH-entry
// queue; the back end maps one queue entry per cycle while its output register
// is empty or being popped, through the default and extension tables into that
// register. An octet is accepted every cycle while the queue has two free
// entries; sustained rate is set by the single queue read port: one result per
// cycle while results are popped, so octets yielding two characters build up
// entries in the queue. With nothing ahead, an octet's first result is written
// to the queue and then the output register; a second result follows from the
// next entry. Escape septets and octets past a message's end produce no results.
module gsm7_septet_unpack_to_ascii #(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_octet,
    input  logic       i_first_octet,
    input  logic [2:0] i_fill_bits,
    input  logic [7:0] i_septet_total,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_ascii_char,
    output logic       o_last_of_item,
    output logic       o_message_done
);
    import gsm7_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_push         w_push;
    t_rec          w_head;
    logic [CW-1:0] w_count;
    logic          w_deq;
    logic          w_fire;

    assign full   = (w_count > CW'(DEPTH - 2));
    assign w_fire = push && !full;

    gsm7_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_octet        (i_octet),
        .i_first_octet  (i_first_octet),
        .i_fill_bits    (i_fill_bits),
        .i_septet_total (i_septet_total),
        .o_push         (w_push)
    );

    gsm7_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_deq   (w_deq),
        .o_head  (w_head),
        .o_count (w_count)
    );

    gsm7_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_head_valid   (w_count != '0),
        .i_pop          (pop),
        .o_deq          (w_deq),
        .o_empty        (empty),
        .o_ascii_char   (o_ascii_char),
        .o_last_of_item (o_last_of_item),
        .o_message_done (o_message_done)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(DEPTH))
        else $error("queue overflow");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_message_done) |-> o_last_of_item)
        else $error("final septet result not last of its octet");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_fire && w_count == '0 && empty) |=> empty)
        else $error("result appeared with nothing in flight");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> (w_count <= CW'(DEPTH - 2)))
        else $error("queue written without room");

endmodule
